// ----- rtl/wdc_pkg.sv -----
// Shared sizes, codes and types for the word dictionary coder.
package wdc_pkg;

    localparam int DICT_ENTRIES = 256;
    localparam int MAX_WORD_LEN = 32;

    localparam int ENT_W   = $clog2(DICT_ENTRIES);
    localparam int CNT_W   = $clog2(DICT_ENTRIES + 1);
    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int BUF_AW  = $clog2(MAX_WORD_LEN);
    localparam int NCHUNK  = (MAX_WORD_LEN + 7) / 8;
    localparam int CI_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int INDEX_W = 9;

    localparam logic [1:0] KIND_NEW  = 2'd0;
    localparam logic [1:0] KIND_REP  = 2'd1;
    localparam logic [1:0] KIND_BEND = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef logic [MAX_WORD_LEN-1:0][7:0] t_word;

    // Hit carried down the cell chain during a lookup.
    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] idx;
    } t_link;

endpackage

// ----- rtl/wdc_cell.sv -----
// One dictionary entry: stored word, length and a registered lookup stage.
module wdc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [wdc_pkg::ENT_W-1:0] i_cell_idx,
    input  logic [wdc_pkg::CNT_W-1:0] i_entry_count,
    input  wdc_pkg::t_word            i_word,
    input  logic [wdc_pkg::LEN_W-1:0] i_word_len,
    input  logic                      i_wr_en,
    input  wdc_pkg::t_link            i_link,
    output wdc_pkg::t_link            o_link
);
    import wdc_pkg::*;

    t_word            r_text;
    logic [LEN_W-1:0] r_len;
    t_link            r_link;
    t_link            n_link;
    logic             w_valid;
    logic             w_match;
    logic             w_bytes_eq;

    assign w_valid = {1'b0, i_cell_idx} < i_entry_count;

    always_comb begin
        w_bytes_eq = 1'b1;
        for (int j = 0; j < MAX_WORD_LEN; j++) begin
            if (LEN_W'(j) < i_word_len && r_text[j] != i_word[j]) begin
                w_bytes_eq = 1'b0;
            end
        end
    end

    assign w_match = w_valid && (r_len == i_word_len) && w_bytes_eq;

    always_comb begin
        n_link = i_link;
        if (!i_link.hit && w_match) begin
            n_link.hit = 1'b1;
            n_link.idx = CNT_W'(i_cell_idx) + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && {1'b0, i_cell_idx} == i_entry_count) begin
            r_text <= i_word;
            r_len  <= i_word_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

// ----- rtl/word_dictionary_coder.sv -----
// Word dictionary coder: top level with word buffer, control and the cell chain.
// A text byte is taken while the coder is idle. A space, or a newline after other bytes
// on the line, starts a lookup that runs down the chain of DICT_ENTRIES registered cells,
// one cell per cycle, and the word is decided once the lookup has reached the end of the
// chain and the output is free. A known word then sends one result, and a new word sends
// one result per eight-byte chunk, one after another as the output takes them. The next
// byte can be taken in the cycle after the last result is loaded. A newline on an empty
// line presents the block-end result the cycle after it is taken. Input stalls while a
// word is looked up or sent, and while a result waits on a stalled output.
module word_dictionary_coder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [8:0]  o_word_index,
    output logic [63:0] o_text_chunk,
    output logic [3:0]  o_chunk_bytes,
    output logic        o_end_of_word,
    output logic        o_end_of_line,
    output logic        o_truncated
);
    import wdc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_scan;
    logic [CNT_W-1:0] r_count;
    t_word            r_buf;
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic             r_lhc;
    logic             r_eol;
    logic [1:0]       r_kind;
    logic [CNT_W-1:0] r_idx;
    logic [CI_W-1:0]  r_ci;

    logic               r_ov;
    logic [1:0]         r_o_kind;
    logic [INDEX_W-1:0] r_o_index;
    logic [63:0]        r_o_chunk;
    logic [3:0]         r_o_nb;
    logic               r_o_eow;
    logic               r_o_eol;
    logic               r_o_trunc;

    logic             w_out_free;
    logic             w_accept;
    logic             w_wr_en;
    logic             w_load;
    t_link            w_link [DICT_ENTRIES+1];

    logic [LEN_W:0]   w_rem;
    logic [63:0]      w_chunk;
    logic [3:0]       w_nb;
    logic             w_eow;

    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign w_wr_en    = (r_state == S_SCAN) && (r_scan == CNT_W'(DICT_ENTRIES)) &&
                        w_out_free && !w_link[DICT_ENTRIES].hit &&
                        (r_count < CNT_W'(DICT_ENTRIES));

    // A result enters the output register this cycle.
    assign w_load = (r_state == S_EMIT && w_out_free) ||
                    (r_state == S_SCAN && w_out_free && r_scan == CNT_W'(DICT_ENTRIES) &&
                     w_link[DICT_ENTRIES].hit) ||
                    (w_accept && i_text_byte == CH_NEWLINE && !r_lhc);

    assign w_link[0] = '0;

    for (genvar g = 0; g < DICT_ENTRIES; g++) begin : g_cell
        wdc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cell_idx    (ENT_W'(g)),
            .i_entry_count (r_count),
            .i_word        (r_buf),
            .i_word_len    (r_len),
            .i_wr_en       (w_wr_en),
            .i_link        (w_link[g]),
            .o_link        (w_link[g+1])
        );
    end

    // Current chunk of the buffered word.
    always_comb begin
        logic [LEN_W:0] pos;
        w_rem = {1'b0, r_len} - ((LEN_W+1)'(r_ci) << 3);
        for (int b = 0; b < 8; b++) begin
            pos = ((LEN_W+1)'(r_ci) << 3) + (LEN_W+1)'(b);
            if (pos < {1'b0, r_len}) begin
                w_chunk[8*b +: 8] = r_buf[pos[BUF_AW-1:0]];
            end else begin
                w_chunk[8*b +: 8] = 8'd0;
            end
        end
        w_nb  = (w_rem >= (LEN_W+1)'(8)) ? 4'd8 : 4'(w_rem);
        w_eow = (w_rem <= (LEN_W+1)'(8));
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_text_byte != CH_SPACE && i_text_byte != CH_NEWLINE &&
            r_len < LEN_W'(MAX_WORD_LEN)) begin
            r_buf[r_len[BUF_AW-1:0]] <= i_text_byte;
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_o_kind  <= r_kind;
            r_o_index <= INDEX_W'(r_idx);
            r_o_chunk <= w_chunk;
            r_o_nb    <= w_nb;
            r_o_eow   <= w_eow;
            r_o_eol   <= r_eol;
            r_o_trunc <= r_ovf;
        end else if (r_state == S_SCAN && w_out_free && r_scan == CNT_W'(DICT_ENTRIES) &&
                     w_link[DICT_ENTRIES].hit) begin
            r_o_kind  <= KIND_REP;
            r_o_index <= INDEX_W'(w_link[DICT_ENTRIES].idx);
            r_o_chunk <= '0;
            r_o_nb    <= 4'd0;
            r_o_eow   <= 1'b1;
            r_o_eol   <= r_eol;
            r_o_trunc <= r_ovf;
        end else if (w_accept && i_text_byte == CH_NEWLINE && !r_lhc) begin
            r_o_kind  <= KIND_BEND;
            r_o_index <= '0;
            r_o_chunk <= '0;
            r_o_nb    <= 4'd0;
            r_o_eow   <= 1'b1;
            r_o_eol   <= 1'b1;
            r_o_trunc <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
            r_count <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_lhc   <= 1'b0;
            r_eol   <= 1'b0;
            r_kind  <= KIND_NEW;
            r_idx   <= '0;
            r_ci    <= '0;
            r_ov    <= 1'b0;
        end else begin
            // Hold a stalled result, drop a delivered one.
            r_ov <= w_load || (r_ov && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_text_byte == CH_NEWLINE) begin
                            r_lhc <= 1'b0;
                            if (!r_lhc) begin
                                r_count <= '0;
                                r_len   <= '0;
                                r_ovf   <= 1'b0;
                            end else begin
                                r_eol   <= 1'b1;
                                r_scan  <= '0;
                                r_state <= S_SCAN;
                            end
                        end else if (i_text_byte == CH_SPACE) begin
                            r_lhc   <= 1'b1;
                            r_eol   <= 1'b0;
                            r_scan  <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_lhc <= 1'b1;
                            if (r_len < LEN_W'(MAX_WORD_LEN)) begin
                                r_len <= r_len + LEN_W'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan != CNT_W'(DICT_ENTRIES)) begin
                        r_scan <= r_scan + CNT_W'(1);
                    end else if (w_out_free) begin
                        if (w_link[DICT_ENTRIES].hit) begin
                            r_len   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ci    <= '0;
                            r_state <= S_EMIT;
                            if (r_count < CNT_W'(DICT_ENTRIES)) begin
                                r_kind  <= KIND_NEW;
                                r_idx   <= r_count + CNT_W'(1);
                                r_count <= r_count + CNT_W'(1);
                            end else begin
                                r_kind <= KIND_FULL;
                                r_idx  <= '0;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (w_eow) begin
                            r_len   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ci <= r_ci + CI_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_o_kind;
    assign o_word_index  = r_o_index;
    assign o_text_chunk  = r_o_chunk;
    assign o_chunk_bytes = r_o_nb;
    assign o_end_of_word = r_o_eow;
    assign o_end_of_line = r_o_eol;
    assign o_truncated   = r_o_trunc;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DICT_ENTRIES))
        else $error("entry count past dictionary size");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken during lookup or emit");

    a_rep_no_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_REP) |-> (o_chunk_bytes == 4'd0 && o_end_of_word))
        else $error("repeated word carries text");

    a_write_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_state == S_EMIT && r_kind == KIND_NEW))
        else $error("entry stored without new-word emit");

endmodule

// ----- tb/sv/word_dictionary_coder_tb.sv -----
// Testbench for the word dictionary coder: directed and random text against a behavioral coder.
`timescale 1ns / 1ps

module word_dictionary_coder_tb;
    import wdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20 * DICT_ENTRIES + 4000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  word_index;
        logic [63:0] text_chunk;
        logic [3:0]  chunk_bytes;
        logic        end_of_word;
        logic        end_of_line;
        logic        truncated;
    } t_coded;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_text_byte;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [8:0]  o_word_index;
    logic [63:0] o_text_chunk;
    logic [3:0]  o_chunk_bytes;
    logic        o_end_of_word;
    logic        o_end_of_line;
    logic        o_truncated;

    word_dictionary_coder dut (.*);

    // Behavioral coder state
    logic [7:0] cur_word [MAX_WORD_LEN];
    int         cur_len;
    bit         cur_over;
    bit         line_busy;
    logic [7:0] dict_text [DICT_ENTRIES][MAX_WORD_LEN];
    int         dict_len [DICT_ENTRIES];
    int         dict_count;

    t_coded     pending_codes [$];
    int         fail_count;
    int         idle_cycles;
    bit         stall_enable;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int find_word();
        int e;
        int k;
        bit same;
        for (e = 0; e < dict_count; e++) begin
            if (dict_len[e] == cur_len) begin
                same = 1'b1;
                for (k = 0; k < cur_len; k++)
                    if (dict_text[e][k] != cur_word[k]) same = 1'b0;
                if (same) return e + 1;
            end
        end
        return 0;
    endfunction

    function automatic void code_word(bit eol);
        t_coded c;
        int hit;
        int pos;
        int nb;
        logic [1:0] kind;
        logic [8:0] idx;
        hit = find_word();
        if (hit != 0) begin
            c = '{KIND_REP, 9'(hit), 64'd0, 4'd0, 1'b1, eol, cur_over};
            pending_codes.insert(pending_codes.size(), c);
            return;
        end
        if (dict_count < DICT_ENTRIES) begin
            for (int k = 0; k < cur_len; k++) dict_text[dict_count][k] = cur_word[k];
            dict_len[dict_count] = cur_len;
            dict_count++;
            kind = KIND_NEW;
            idx = 9'(dict_count);
        end else begin
            kind = KIND_FULL;
            idx = 9'd0;
        end
        pos = 0;
        do begin
            c = '{kind, idx, 64'd0, 4'd0, 1'b0, eol, cur_over};
            nb = 0;
            while (nb < 8 && pos < cur_len) begin
                c.text_chunk[8*nb +: 8] = cur_word[pos];
                nb++;
                pos++;
            end
            c.chunk_bytes = 4'(nb);
            c.end_of_word = (pos >= cur_len);
            pending_codes.insert(pending_codes.size(), c);
        end while (pos < cur_len);
    endfunction

    function automatic void code_byte(logic [7:0] b);
        t_coded c;
        if (b == CH_NEWLINE) begin
            if (!line_busy) begin
                c = '{KIND_BEND, 9'd0, 64'd0, 4'd0, 1'b1, 1'b1, 1'b0};
                pending_codes.insert(pending_codes.size(), c);
                dict_count = 0;
            end else begin
                code_word(1'b1);
            end
            cur_len = 0;
            cur_over = 1'b0;
            line_busy = 1'b0;
        end else if (b == CH_SPACE) begin
            code_word(1'b0);
            cur_len = 0;
            cur_over = 1'b0;
            line_busy = 1'b1;
        end else begin
            if (cur_len < MAX_WORD_LEN) begin
                cur_word[cur_len] = b;
                cur_len++;
            end else begin
                cur_over = 1'b1;
            end
            line_busy = 1'b1;
        end
    endfunction

    function automatic int gap_len();
        if ($urandom_range(3) != 0) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // Transfer one text byte and predict what it causes.
    task automatic send_byte(logic [7:0] b);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_valid     <= 1'b0;
            i_text_byte <= 8'($urandom);
            repeat (g) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (o_stall);
        code_byte(b);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic send_word_bytes(int n);
        for (int k = 0; k < n; k++) send_byte(8'($urandom_range(126, 33)));
    endtask

    // Drop valid and hold off until every predicted result has come out.
    task automatic wait_drained();
        i_valid     <= 1'b0;
        i_text_byte <= 8'($urandom);
        @(posedge i_clk);
        while (pending_codes.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random stall, compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_coded want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_codes.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    want = pending_codes.pop_front();
                    if (o_kind != want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_kind);
                        fail_count++;
                    end
                    if (o_word_index != want.word_index) begin
                        $error("word_index: expected %0d, got %0d", want.word_index, o_word_index);
                        fail_count++;
                    end
                    if (o_text_chunk != want.text_chunk) begin
                        $error("text_chunk: expected %h, got %h", want.text_chunk, o_text_chunk);
                        fail_count++;
                    end
                    if (o_chunk_bytes != want.chunk_bytes) begin
                        $error("chunk_bytes: expected %0d, got %0d",
                               want.chunk_bytes, o_chunk_bytes);
                        fail_count++;
                    end
                    if (o_end_of_word != want.end_of_word) begin
                        $error("end_of_word: expected %0d, got %0d",
                               want.end_of_word, o_end_of_word);
                        fail_count++;
                    end
                    if (o_end_of_line != want.end_of_line) begin
                        $error("end_of_line: expected %0d, got %0d",
                               want.end_of_line, o_end_of_line);
                        fail_count++;
                    end
                    if (o_truncated != want.truncated) begin
                        $error("truncated: expected %0d, got %0d", want.truncated, o_truncated);
                        fail_count++;
                    end
                end
            end
            if (!stall_enable || $urandom_range(2) != 0) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(15) == 0) ? 1'b1 : ($urandom_range(1) == 1);
        end
    end

    // Count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** word_dictionary_coder: FAILED **");
                $finish;
            end
        end
    end

    task automatic test_separators_and_blocks();
        send_text("\n");
        send_text("  \n");
        send_text("a a\n");
        send_text("\n");
        send_text("a\n");
    endtask

    task automatic test_chunking();
        send_word_bytes(7);  send_byte(CH_SPACE);
        send_word_bytes(8);  send_byte(CH_SPACE);
        send_word_bytes(9);  send_byte(CH_SPACE);
        send_word_bytes(32); send_byte(CH_SPACE);
        send_text("\x01\x09\x0b\x1f\x21\x7f\x80\xff\n");
    endtask

    task automatic test_truncation();
        // Two long words sharing their first bytes must match once clipped.
        send_text("abcdefghijklmnopqrstuvwxyzABCDEF12345 ");
        send_text("abcdefghijklmnopqrstuvwxyzABCDEFzz\n");
        send_text("\n");
    endtask

    task automatic test_full_dictionary();
        // One-byte words fill all but two entries.
        for (int v = 0; v < 256; v++) begin
            if (8'(v) != CH_SPACE && 8'(v) != CH_NEWLINE) begin
                send_byte(8'(v));
                send_byte(CH_SPACE);
            end
        end
        // Empty word and one two-byte word take the last entries.
        send_byte(CH_SPACE);
        send_text("ab ");
        // Known word on a full dictionary, then one that cannot be stored.
        send_text("ab zz\n");
        wait_drained();
        send_text("\n");
    endtask

    task automatic test_random_text();
        int n;
        bit drained;
        n = 0;
        drained = 1'b0;
        while (n < 40) begin
            case ($urandom_range(9))
                0: begin send_byte(8'($urandom)); n++; end
                1: begin send_byte(CH_NEWLINE); n++; end
                2, 3: begin send_byte(8'($urandom_range(99, 97))); send_byte(CH_SPACE); n += 2; end
                default: begin
                    int len;
                    len = ($urandom_range(19) == 0) ? $urandom_range(40, 30)
                                                    : $urandom_range(5, 0);
                    send_word_bytes(len);
                    send_byte(($urandom_range(4) == 0) ? CH_NEWLINE : CH_SPACE);
                    n += len + 1;
                end
            endcase
            if (!drained && n >= 20) begin
                wait_drained();
                drained = 1'b1;
            end
        end
        send_text("x\n\n");
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_text_byte  = 8'd0;
        stall_enable = 1'b0;
        fail_count   = 0;
        idle_cycles  = 0;
        cur_len      = 0;
        cur_over     = 1'b0;
        line_busy    = 1'b0;
        dict_count   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_separators_and_blocks();
        stall_enable <= 1'b1;
        test_chunking();
        test_truncation();
        test_full_dictionary();
        test_random_text();
        wait_drained();
        repeat (DICT_ENTRIES + 50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** word_dictionary_coder: PASSED **");
        end else begin
            $display("** word_dictionary_coder: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/wdc_pkg.sv
rtl/wdc_cell.sv
rtl/word_dictionary_coder.sv
tb/sv/word_dictionary_coder_tb.sv
